// ===== design/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator package
// Shared types, state codes, timing constants and the per-state look table.
// ----------------------------------------------------------------------------
package slpg_pkg;

  localparam int unsigned NumStates        = 17;
  localparam int unsigned StateW           = 5;
  localparam int unsigned FullLevelDefault = 30;

  // Animation timing in milliseconds.
  localparam int unsigned BlinkMs       = 200;
  localparam int unsigned PulseMs       = 20;
  localparam int unsigned PulsePeriodMs = 2000;
  localparam int unsigned PulseHalfMs   = 1000;

  // Configuration register indexes (byte address bit 2).
  localparam logic RegIdxCancel = 1'b0;
  localparam logic RegIdxBypass = 1'b1;

  // Indicator state codes.
  localparam logic [StateW-1:0] StOff         = 5'd0;
  localparam logic [StateW-1:0] StBoot        = 5'd1;
  localparam logic [StateW-1:0] StLinkLost    = 5'd2;
  localparam logic [StateW-1:0] StWifiLost    = 5'd3;
  localparam logic [StateW-1:0] StError       = 5'd4;
  localparam logic [StateW-1:0] StUpdate      = 5'd5;
  localparam logic [StateW-1:0] StPairListen  = 5'd6;
  localparam logic [StateW-1:0] StBlePair     = 5'd7;
  localparam logic [StateW-1:0] StResultOk    = 5'd8;
  localparam logic [StateW-1:0] StResultFail  = 5'd9;
  localparam logic [StateW-1:0] StUnpair      = 5'd10;
  localparam logic [StateW-1:0] StPortal      = 5'd11;
  localparam logic [StateW-1:0] StWifiTrial   = 5'd12;
  localparam logic [StateW-1:0] StSafeMode    = 5'd13;
  localparam logic [StateW-1:0] StIdentify    = 5'd14;
  localparam logic [StateW-1:0] StButtonPair  = 5'd15;
  localparam logic [StateW-1:0] StButtonWipe  = 5'd16;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_STATE = 2'd1,
    FUNC_HOLD  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_SOLID = 2'd0,
    KIND_BLINK = 2'd1,
    KIND_PULSE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    LVL_ZERO       = 2'd0,
    LVL_FULL       = 2'd1,
    LVL_HALF       = 2'd2,
    LVL_TWO_THIRDS = 2'd3
  } lvl_e;

  typedef struct packed {
    kind_e kind;
    lvl_e  r;
    lvl_e  g;
    lvl_e  b;
  } look_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [StateW-1:0] state_code;
    logic [31:0]       hold_ms;
    logic [31:0]       now_ms;
  } item_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              refresh;
    logic [StateW-1:0] shown_state;
  } result_t;

  typedef struct packed {
    logic [NumStates-1:0] cancel_mask;
    logic [NumStates-1:0] bypass_mask;
  } cfg_t;

  typedef struct packed {
    logic [StateW-1:0] cur_state;
    logic [31:0]       state_start_ms;
    logic [31:0]       last_toggle_ms;
    logic              blink_lit;
    logic [31:0]       hold_deadline_ms;
    logic              hold_armed;
    logic [StateW-1:0] hold_target;
    rgb_t              colour;
  } core_state_t;

  // Animation kind and colour recipe of each indicator state.
  function automatic look_t look_of(logic [StateW-1:0] code);
    look_t lk;
    case (code)
      StBoot:       lk = '{KIND_SOLID, LVL_FULL, LVL_FULL, LVL_FULL};
      StLinkLost:   lk = '{KIND_SOLID, LVL_FULL, LVL_ZERO, LVL_ZERO};
      StWifiLost:   lk = '{KIND_SOLID, LVL_ZERO, LVL_ZERO, LVL_FULL};
      StError:      lk = '{KIND_BLINK, LVL_FULL, LVL_ZERO, LVL_ZERO};
      StUpdate:     lk = '{KIND_PULSE, LVL_FULL, LVL_FULL, LVL_FULL};
      StPairListen: lk = '{KIND_PULSE, LVL_FULL, LVL_ZERO, LVL_FULL};
      StBlePair:    lk = '{KIND_PULSE, LVL_ZERO, LVL_FULL, LVL_FULL};
      StResultOk:   lk = '{KIND_SOLID, LVL_ZERO, LVL_FULL, LVL_ZERO};
      StResultFail: lk = '{KIND_BLINK, LVL_FULL, LVL_ZERO, LVL_ZERO};
      StUnpair:     lk = '{KIND_BLINK, LVL_FULL, LVL_HALF, LVL_ZERO};
      StPortal:     lk = '{KIND_PULSE, LVL_ZERO, LVL_ZERO, LVL_FULL};
      StWifiTrial:  lk = '{KIND_BLINK, LVL_ZERO, LVL_ZERO, LVL_FULL};
      StSafeMode:   lk = '{KIND_PULSE, LVL_FULL, LVL_TWO_THIRDS, LVL_ZERO};
      StIdentify:   lk = '{KIND_BLINK, LVL_FULL, LVL_FULL, LVL_FULL};
      StButtonPair: lk = '{KIND_SOLID, LVL_FULL, LVL_ZERO, LVL_FULL};
      StButtonWipe: lk = '{KIND_BLINK, LVL_FULL, LVL_ZERO, LVL_ZERO};
      default:      lk = '{KIND_SOLID, LVL_ZERO, LVL_ZERO, LVL_ZERO};
    endcase
    return lk;
  endfunction

endpackage

// ===== design/slpg_intf.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface slpg_item_if import slpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [StateW-1:0] state_code;
  logic [31:0]       hold_ms;
  logic [31:0]       now_ms;

  modport source (output valid, func, state_code, hold_ms, now_ms, input ready);
  modport sink   (input valid, func, state_code, hold_ms, now_ms, output ready);
endinterface

interface slpg_result_if import slpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              refresh;
  logic [StateW-1:0] shown_state;

  modport source (output valid, red, green, blue, refresh, shown_state, input ready);
  modport sink   (input valid, red, green, blue, refresh, shown_state, output ready);
endinterface

// ===== design/slpg_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator configuration registers
// APB-style slave holding the hold-cancel and hold-bypass state masks.
// ----------------------------------------------------------------------------
module slpg_apb_regs import slpg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [NumStates-1:0] cancel_q, cancel_d;
  logic [NumStates-1:0] bypass_q, bypass_d;
  logic                 wr_en;
  logic                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  always_comb begin
    cancel_d = cancel_q;
    bypass_d = bypass_q;
    if (wr_en) begin
      case (reg_idx)
        RegIdxCancel: cancel_d = pwdata[NumStates-1:0];
        RegIdxBypass: bypass_d = pwdata[NumStates-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cancel_q <= '0;
      bypass_q <= '0;
    end else begin
      cancel_q <= cancel_d;
      bypass_q <= bypass_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegIdxCancel: prdata = {{(32 - NumStates){1'b0}}, cancel_q};
      RegIdxBypass: prdata = {{(32 - NumStates){1'b0}}, bypass_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = '{cancel_mask: cancel_q, bypass_mask: bypass_q};

endmodule

// ===== design/slpg_pulse_level.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator pulse brightness
// Triangle brightness from the state age and scaling of the state's colour.
// ----------------------------------------------------------------------------
module slpg_pulse_level import slpg_pkg::*; #(
  parameter int unsigned FullLevel = FullLevelDefault
) (
  input  logic [31:0] age_i,
  input  look_t       look_i,
  output rgb_t        colour_o
);

  localparam int unsigned HalfLevel     = FullLevel / 2;
  localparam int unsigned TwoThirdLevel = (FullLevel * 2) / 3;
  // floor(d * FullLevel / 1000) equals (d * RecipMul) >> 20 for every d up to
  // 1000, because the rounding error of the reciprocal stays below 1/1000.
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipMul   = (FullLevel * (2 ** RecipShift) + PulseHalfMs - 1)
                                       / PulseHalfMs;
  localparam logic [29:0] RecipMulW  = 30'(RecipMul);

  logic [27:0] age_hi;
  logic [12:0] fold1;
  logic [7:0]  fold2;
  logic [6:0]  rem125;
  logic [10:0] phase;
  logic [9:0]  ramp_pos;
  logic [29:0] prod;
  logic [7:0]  lvl;
  logic [7:0]  half_tab [256];
  logic [7:0]  third_tab [256];

  // The 2000 ms period is 16 * 125: the low four bits pass straight through
  // and the rest is reduced modulo 125 by folding 7-bit digits, using
  // 2^7 = 3, 2^14 = 9 and 2^21 = 27 modulo 125.
  assign age_hi = age_i[31:4];
  assign fold1  = 13'(age_hi[6:0])
                + 13'(age_hi[13:7])  * 13'd3
                + 13'(age_hi[20:14]) * 13'd9
                + 13'(age_hi[27:21]) * 13'd27;
  assign fold2  = 8'(fold1[6:0]) + 8'(fold1[12:7]) * 8'd3;
  assign rem125 = (fold2 >= 8'd125) ? 7'(fold2 - 8'd125) : 7'(fold2);
  assign phase  = {rem125, age_i[3:0]};

  // Distance from the dark end of the triangle.
  assign ramp_pos = (phase < 11'(PulseHalfMs)) ? 10'(phase)
                                               : 10'(11'(PulsePeriodMs) - phase);
  assign prod     = {20'd0, ramp_pos} * RecipMulW;
  assign lvl      = prod[RecipShift +: 8];

  // Scaled colour components that are not simply zero or the level itself.
  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam int unsigned HalfVal  = (HalfLevel * i) / FullLevel;
    localparam int unsigned ThirdVal = (TwoThirdLevel * i) / FullLevel;
    assign half_tab[i]  = 8'(HalfVal);
    assign third_tab[i] = 8'(ThirdVal);
  end

  function automatic logic [7:0] scale(lvl_e l, logic [7:0] v,
                                       logic [7:0] hv, logic [7:0] tv);
    logic [7:0] s;
    case (l)
      LVL_ZERO:       s = 8'd0;
      LVL_FULL:       s = v;
      LVL_HALF:       s = hv;
      LVL_TWO_THIRDS: s = tv;
      default:        s = 8'd0;
    endcase
    return s;
  endfunction

  assign colour_o.r = scale(look_i.r, lvl, half_tab[lvl], third_tab[lvl]);
  assign colour_o.g = scale(look_i.g, lvl, half_tab[lvl], third_tab[lvl]);
  assign colour_o.b = scale(look_i.b, lvl, half_tab[lvl], third_tab[lvl]);

endmodule

// ===== design/slpg_step.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator step logic
// Works out the next indicator state and the result for one request word.
// ----------------------------------------------------------------------------
module slpg_step import slpg_pkg::*; #(
  parameter int unsigned FullLevel = FullLevelDefault
) (
  input  item_t       item_i,
  input  core_state_t state_i,
  input  cfg_t        cfg_i,
  output core_state_t state_o,
  output result_t     result_o
);

  localparam logic [7:0] FullVal  = 8'(FullLevel);
  localparam logic [7:0] HalfVal  = 8'(FullLevel / 2);
  localparam logic [7:0] ThirdVal = 8'((FullLevel * 2) / 3);

  look_t       cur_look;
  rgb_t        pulse_colour;
  logic [31:0] age;

  function automatic logic [7:0] solid_level(lvl_e l);
    logic [7:0] s;
    case (l)
      LVL_ZERO:       s = 8'd0;
      LVL_FULL:       s = FullVal;
      LVL_HALF:       s = HalfVal;
      LVL_TWO_THIRDS: s = ThirdVal;
      default:        s = 8'd0;
    endcase
    return s;
  endfunction

  function automatic rgb_t solid_colour(look_t lk);
    rgb_t c;
    c.r = solid_level(lk.r);
    c.g = solid_level(lk.g);
    c.b = solid_level(lk.b);
    return c;
  endfunction

  assign cur_look = look_of(state_i.cur_state);
  assign age      = item_i.now_ms - state_i.state_start_ms;

  slpg_pulse_level #(
    .FullLevel(FullLevel)
  ) u_pulse (
    .age_i   (age),
    .look_i  (cur_look),
    .colour_o(pulse_colour)
  );

  always_comb begin
    core_state_t       nxt;
    logic              refresh;
    logic [31:0]       since_toggle;
    logic [31:0]       hold_left;
    logic [StateW-1:0] req;
    look_t             req_look;

    nxt          = state_i;
    refresh      = 1'b0;
    since_toggle = item_i.now_ms - state_i.last_toggle_ms;
    hold_left    = state_i.hold_deadline_ms - item_i.now_ms;
    req          = item_i.state_code;
    req_look     = look_of(req);

    case (item_i.func)
      FUNC_TICK: begin
        case (cur_look.kind)
          KIND_BLINK: begin
            if (since_toggle >= 32'(BlinkMs)) begin
              nxt.last_toggle_ms = item_i.now_ms;
              nxt.blink_lit      = !state_i.blink_lit;
              nxt.colour         = state_i.blink_lit ? '0 : solid_colour(cur_look);
              refresh            = 1'b1;
            end
          end
          KIND_PULSE: begin
            if (since_toggle >= 32'(PulseMs)) begin
              nxt.last_toggle_ms = item_i.now_ms;
              nxt.colour         = pulse_colour;
              refresh            = 1'b1;
            end
          end
          default: ;
        endcase
      end

      FUNC_STATE: begin
        if (item_i.state_code < StateW'(NumStates)) begin
          // An armed hold ends on a cancelling state or once its deadline
          // is reached or has passed; otherwise it redirects everything but bypass states.
          if (state_i.hold_armed) begin
            if (cfg_i.cancel_mask[item_i.state_code] || hold_left[31] ||
                (hold_left == 32'd0)) begin
              nxt.hold_armed       = 1'b0;
              nxt.hold_deadline_ms = '0;
            end else if (!cfg_i.bypass_mask[item_i.state_code]) begin
              req = state_i.hold_target;
            end
          end
          req_look = look_of(req);
          if (req != state_i.cur_state) begin
            nxt.cur_state      = req;
            nxt.state_start_ms = item_i.now_ms;
            nxt.last_toggle_ms = item_i.now_ms;
            nxt.blink_lit      = (req_look.kind == KIND_BLINK);
            // A pulse state keeps the old colour until its first refresh.
            if (req_look.kind != KIND_PULSE) begin
              nxt.colour = solid_colour(req_look);
              refresh    = 1'b1;
            end
          end
        end
      end

      FUNC_HOLD: begin
        if (item_i.state_code < StateW'(NumStates)) begin
          nxt.hold_target      = item_i.state_code;
          nxt.hold_deadline_ms = item_i.now_ms + item_i.hold_ms;
          nxt.hold_armed       = 1'b1;
        end
      end

      default: ;
    endcase

    state_o              = nxt;
    result_o.red         = nxt.colour.r;
    result_o.green       = nxt.colour.g;
    result_o.blue        = nxt.colour.b;
    result_o.refresh     = refresh;
    result_o.shown_state = nxt.cur_state;
  end

endmodule

// ===== design/status_led_pattern_generator_core.sv =====
// ----------------------------------------------------------------------------
// Status LED pattern generator core
// Drives one RGB status pixel from request words: animation ticks, state
// requests with a timed hold override, and hold requests.
// ----------------------------------------------------------------------------
// Path: a request word is held in the input register, then in the result
// register; a receiver stall can keep it waiting in the input register.
// Throughput: one word per cycle while the receiver takes results; the step
// logic evaluates a whole word, including the pulse brightness multiply,
// combinationally between the input register and the result register.
// Reset: rst_ni clears both pipeline valids, the masks and all indicator state
// to the off state with a dark pixel and no hold armed.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_core import slpg_pkg::*; #(
  parameter int unsigned FullLevel = FullLevelDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  slpg_item_if.sink           item_i,
  slpg_result_if.source       result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t        cfg;
  item_t       in_word;
  item_t       in_q;
  logic        in_valid_q, in_valid_d;
  result_t     res_d, res_q;
  logic        res_valid_q, res_valid_d;
  core_state_t state_q, state_d;
  logic        load;
  logic        advance;

  // Configuration registers. Software must write them only while the block is
  // idle, which the block itself does not enforce; the step logic uses them directly.
  slpg_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // The word in the input register moves to the result register whenever
  // that register is empty or is being drained in the same cycle. The
  // indicator state is committed at the same edge, so the next word, loaded
  // at that edge too, already sees it and words can follow each other without gaps.
  assign advance      = in_valid_q & (~res_valid_q | result_o.ready);
  assign item_i.ready = ~in_valid_q | advance;
  assign load         = item_i.valid & item_i.ready;

  assign in_word = '{func:       item_i.func,
                     state_code: item_i.state_code,
                     hold_ms:    item_i.hold_ms,
                     now_ms:     item_i.now_ms};

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // All per-word work: tick timing, hold check, state change and pulse level.
  slpg_step #(
    .FullLevel(FullLevel)
  ) u_step (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset; their valids qualify them.
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_q <= in_word;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.red         = res_q.red;
  assign result_o.green       = res_q.green;
  assign result_o.blue        = res_q.blue;
  assign result_o.refresh     = res_q.refresh;
  assign result_o.shown_state = res_q.shown_state;

endmodule

// ===== tb/sv/slpg_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status LED pattern generator result checker
// Watches the request, result and register channels and keeps its own model
// of the pixel state. Each result word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module slpg_checker import slpg_pkg::*; #(
  parameter int unsigned FullLevel = FullLevelDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slpg_item_if        item_i,
  slpg_result_if      result_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatches_o,
  output int unsigned awaiting_o,
  output int unsigned checked_o,
  output int unsigned refreshes_o
);

  localparam int unsigned ReportCap = 40;

  localparam logic [7:0] LvlFull      = 8'(FullLevel);
  localparam logic [7:0] LvlHalf      = 8'(FullLevel / 2);
  localparam logic [7:0] LvlTwoThirds = 8'((FullLevel * 2) / 3);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_look_t;

  // Register copies and the predicted indicator state.
  logic [NumStates-1:0] cancel_bits;
  logic [NumStates-1:0] bypass_bits;
  logic [StateW-1:0]    shown;
  logic [StateW-1:0]    held_state;
  logic [31:0]          entered_ms;
  logic [31:0]          last_step_ms;
  logic [31:0]          hold_until_ms;
  logic                 lit;
  logic                 hold_on;
  rgb_t                 colour;

  result_t pixel_words_due[$];

  function automatic pixel_look_t look_for(logic [StateW-1:0] code);
    pixel_look_t lk;
    case (code)
      StBoot:       lk = '{KIND_SOLID, LvlFull, LvlFull, LvlFull};
      StLinkLost:   lk = '{KIND_SOLID, LvlFull, 8'd0, 8'd0};
      StWifiLost:   lk = '{KIND_SOLID, 8'd0, 8'd0, LvlFull};
      StError:      lk = '{KIND_BLINK, LvlFull, 8'd0, 8'd0};
      StUpdate:     lk = '{KIND_PULSE, LvlFull, LvlFull, LvlFull};
      StPairListen: lk = '{KIND_PULSE, LvlFull, 8'd0, LvlFull};
      StBlePair:    lk = '{KIND_PULSE, 8'd0, LvlFull, LvlFull};
      StResultOk:   lk = '{KIND_SOLID, 8'd0, LvlFull, 8'd0};
      StResultFail: lk = '{KIND_BLINK, LvlFull, 8'd0, 8'd0};
      StUnpair:     lk = '{KIND_BLINK, LvlFull, LvlHalf, 8'd0};
      StPortal:     lk = '{KIND_PULSE, 8'd0, 8'd0, LvlFull};
      StWifiTrial:  lk = '{KIND_BLINK, 8'd0, 8'd0, LvlFull};
      StSafeMode:   lk = '{KIND_PULSE, LvlFull, LvlTwoThirds, 8'd0};
      StIdentify:   lk = '{KIND_BLINK, LvlFull, LvlFull, LvlFull};
      StButtonPair: lk = '{KIND_SOLID, LvlFull, 8'd0, LvlFull};
      StButtonWipe: lk = '{KIND_BLINK, LvlFull, 8'd0, 8'd0};
      default:      lk = '{KIND_SOLID, 8'd0, 8'd0, 8'd0};
    endcase
    return lk;
  endfunction

  // Triangle brightness: 0 up to full level over one half period and back.
  function automatic logic [31:0] pulse_level(logic [31:0] age);
    logic [31:0] ph;
    ph = age % PulsePeriodMs;
    if (ph < PulseHalfMs) begin
      return (ph * FullLevel) / PulseHalfMs;
    end
    return ((PulsePeriodMs - ph) * FullLevel) / PulseHalfMs;
  endfunction

  // Advances the predicted state by one request word and gives its result.
  task automatic step_pixel(input item_t w, output result_t res);
    pixel_look_t       lk;
    logic [StateW-1:0] want;
    logic [31:0]       age;
    logic [31:0]       left;
    logic [31:0]       lvl;
    logic              fresh;
    fresh = 1'b0;
    case (w.func)
      FUNC_TICK: begin
        lk  = look_for(shown);
        age = w.now_ms - last_step_ms;
        if (lk.kind == KIND_BLINK && age >= BlinkMs) begin
          last_step_ms = w.now_ms;
          lit          = !lit;
          if (lit) begin
            colour = '{lk.r, lk.g, lk.b};
          end else begin
            colour = '0;
          end
          fresh = 1'b1;
        end else if (lk.kind == KIND_PULSE && age >= PulseMs) begin
          last_step_ms = w.now_ms;
          lvl          = pulse_level(w.now_ms - entered_ms);
          colour.r     = 8'((32'(lk.r) * lvl) / FullLevel);
          colour.g     = 8'((32'(lk.g) * lvl) / FullLevel);
          colour.b     = 8'((32'(lk.b) * lvl) / FullLevel);
          fresh        = 1'b1;
        end
      end
      FUNC_STATE: begin
        want = w.state_code;
        if (want < NumStates) begin
          if (hold_on) begin
            // The hold ends when cancelled or when the deadline is reached,
            // with the remaining time read as a signed value.
            left = hold_until_ms - w.now_ms;
            if (cancel_bits[want] || left[31] || left == 32'd0) begin
              hold_on       = 1'b0;
              hold_until_ms = 32'd0;
            end else if (!bypass_bits[want]) begin
              want = held_state;
            end
          end
          if (want != shown) begin
            shown        = want;
            entered_ms   = w.now_ms;
            last_step_ms = w.now_ms;
            lit          = 1'b0;
            lk           = look_for(want);
            // Pulse states keep the present colour until their first refresh.
            if (lk.kind != KIND_PULSE) begin
              lit    = (lk.kind == KIND_BLINK);
              colour = '{lk.r, lk.g, lk.b};
              fresh  = 1'b1;
            end
          end
        end
      end
      FUNC_HOLD: begin
        if (w.state_code < NumStates) begin
          held_state    = w.state_code;
          hold_until_ms = w.now_ms + w.hold_ms;
          hold_on       = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res = '{colour.r, colour.g, colour.b, fresh, shown};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] due);
    if (mismatches_o < ReportCap) begin
      $display("[%0t] mismatch on %s after %0d result words: got 0x%0h, expected 0x%0h",
               $realtime, what, checked_o, got, due);
    end
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t   w;
    result_t got;
    result_t due;
    if (!rst_ni) begin
      cancel_bits   = '0;
      bypass_bits   = '0;
      shown         = StOff;
      held_state    = StOff;
      entered_ms    = '0;
      last_step_ms  = '0;
      hold_until_ms = '0;
      lit           = 1'b0;
      hold_on       = 1'b0;
      colour        = '0;
      pixel_words_due.delete();
      mismatches_o  = 0;
      awaiting_o    = 0;
      checked_o     = 0;
      refreshes_o   = 0;
    end else begin
      // Register port: writes update the copies, reads are checked against them.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == RegIdxCancel) begin
            cancel_bits = pwdata[NumStates-1:0];
          end else begin
            bypass_bits = pwdata[NumStates-1:0];
          end
        end else if (paddr[2] == RegIdxCancel) begin
          if (prdata[NumStates-1:0] != cancel_bits) begin
            report_mismatch("cancel_mask read", prdata, 32'(cancel_bits));
          end
        end else if (prdata[NumStates-1:0] != bypass_bits) begin
          report_mismatch("bypass_mask read", prdata, 32'(bypass_bits));
        end
      end

      if (result_i.valid && result_i.ready) begin
        got = '{result_i.red, result_i.green, result_i.blue, result_i.refresh,
                result_i.shown_state};
        if (got.refresh) begin
          refreshes_o++;
        end
        if (pixel_words_due.size() == 0) begin
          report_mismatch("unexpected result word", 32'(got), 32'd0);
        end else begin
          due = pixel_words_due.pop_front();
          if (got.red != due.red) begin
            report_mismatch("red", 32'(got.red), 32'(due.red));
          end
          if (got.green != due.green) begin
            report_mismatch("green", 32'(got.green), 32'(due.green));
          end
          if (got.blue != due.blue) begin
            report_mismatch("blue", 32'(got.blue), 32'(due.blue));
          end
          if (got.refresh != due.refresh) begin
            report_mismatch("refresh", 32'(got.refresh), 32'(due.refresh));
          end
          if (got.shown_state != due.shown_state) begin
            report_mismatch("shown_state", 32'(got.shown_state), 32'(due.shown_state));
          end
        end
        checked_o++;
      end

      if (item_i.valid && item_i.ready) begin
        w = '{item_i.func, item_i.state_code, item_i.hold_ms, item_i.now_ms};
        step_pixel(w, due);
        pixel_words_due.push_back(due);
      end
      awaiting_o = pixel_words_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_status_led_pattern_generator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status LED pattern generator testbench
// Drives request words and mask settings into the core and lets the checker
// compare every result word. A short directed sequence is followed by random
// phases with different masks, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_generator_core;
  import slpg_pkg::*;

  localparam int unsigned FullLevel     = FullLevelDefault;
  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned RandomPhases  = 7;
  localparam int unsigned WordsPerPhase = 100;
  localparam int unsigned SettleCycles  = 4;

  // The fourth function code has no meaning and must be ignored.
  localparam logic [1:0]  FuncUnused = 2'd3;
  localparam logic [31:0] MaskAll    = 32'h0001_FFFF;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN,
    STALL_RUNS
  } stall_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slpg_item_if   item_if ();
  slpg_result_if result_if ();

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned checked;
  int unsigned refreshes;

  int unsigned cycle_count = 0;
  int unsigned sent_words = 0;
  int unsigned settings_applied = 0;
  int unsigned burst_left;
  int unsigned burst_max;
  int unsigned gap_max;
  stall_e      stall_mode;

  // Millisecond uptime that the random requests carry; it mostly moves forward
  // in small steps so that blinks and pulses get to animate.
  logic [31:0] ms_clock;

  status_led_pattern_generator_core #(
    .FullLevel(FullLevel)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  slpg_checker #(
    .FullLevel(FullLevel)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_if),
    .result_i     (result_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .awaiting_o   (awaiting),
    .checked_o    (checked),
    .refreshes_o  (refreshes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d result words outstanding.",
               cycle_count, awaiting);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The result receiver stalls on its own pattern, chosen per phase. Ready
  // changes only at the falling edge.
  initial begin : receiver
    int unsigned run_left;
    int unsigned pattern_cnt;
    logic        level;
    result_if.ready = 1'b0;
    run_left        = 0;
    pattern_cnt     = 0;
    level           = 1'b1;
    forever begin
      @(negedge clk_i);
      case (stall_mode)
        STALL_NONE: begin
          result_if.ready = 1'b1;
        end
        STALL_RANDOM: begin
          result_if.ready = ($urandom_range(0, 3) != 0);
        end
        STALL_PATTERN: begin
          result_if.ready = ((pattern_cnt % 7) < 4);
          pattern_cnt++;
        end
        default: begin
          // Alternating runs of ready and stall of random length.
          if (run_left == 0) begin
            level    = !level;
            run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 20);
          end
          run_left--;
          result_if.ready = level;
        end
      endcase
    end
  end

  // Presents one request word at a falling edge and returns at the falling
  // edge after it is taken. Bursts of random length alternate with gaps.
  task automatic send_word(input logic [1:0] func, input logic [StateW-1:0] code,
                           input logic [31:0] hold, input logic [31:0] now);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        item_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    item_if.func       = func;
    item_if.state_code = code;
    item_if.hold_ms    = hold;
    item_if.now_ms     = now;
    item_if.valid      = 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    sent_words++;
    @(negedge clk_i);
  endtask

  // One register access: a setup phase, then an access phase until pready.
  task automatic reg_access(input logic idx, input logic wr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Writes both masks and reads them back; the checker compares the reads.
  task automatic apply_masks(input logic [31:0] cancel_val, input logic [31:0] bypass_val);
    reg_access(RegIdxCancel, 1'b1, cancel_val);
    reg_access(RegIdxBypass, 1'b1, bypass_val);
    reg_access(RegIdxCancel, 1'b0, 32'd0);
    reg_access(RegIdxBypass, 1'b0, 32'd0);
    settings_applied++;
  endtask

  // Drains the pipeline so that the masks can be written while idle.
  task automatic settle();
    item_if.valid = 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Random request word. Most words are ticks and valid requests on a time
  // line that moves forward; the rest are ignored words and jumps in time,
  // including jumps to just before the 32-bit wrap.
  task automatic send_random_word();
    int unsigned       pick;
    int unsigned       hold_pick;
    logic [1:0]        func;
    logic [StateW-1:0] code;
    logic [31:0]       hold;
    pick      = $urandom_range(0, 99);
    hold_pick = $urandom_range(0, 19);
    code      = StateW'($urandom_range(0, NumStates - 1));
    hold      = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      ms_clock = ms_clock + $urandom_range(100, 450);
    end else begin
      ms_clock = ms_clock + $urandom_range(0, 40);
    end
    if (pick < 55) begin
      // Ticks carry random contents in the fields that they do not use.
      func = FUNC_TICK;
      code = StateW'($urandom_range(0, 31));
    end else if (pick < 77) begin
      func = FUNC_STATE;
    end else if (pick < 89) begin
      func = FUNC_HOLD;
      if (hold_pick < 12) begin
        hold = $urandom_range(1, 1500);
      end else if (hold_pick < 15) begin
        hold = 32'd0;
      end else if (hold_pick < 18) begin
        // Deadline lands exactly on zero.
        hold = 32'd0 - ms_clock;
      end
    end else if (pick < 95) begin
      if ($urandom_range(0, 1) == 0) begin
        func = FuncUnused;
        code = StateW'($urandom_range(0, 31));
      end else begin
        func = 2'($urandom_range(FUNC_STATE, FUNC_HOLD));
        code = StateW'($urandom_range(NumStates, 31));
      end
    end else begin
      func = FUNC_TICK;
      if ($urandom_range(0, 1) == 0) begin
        ms_clock = $urandom;
      end else begin
        ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 600);
      end
    end
    send_word(func, code, hold, ms_clock);
  endtask

  initial begin
    rst_ni             = 1'b0;
    item_if.valid      = 1'b0;
    item_if.func       = FUNC_TICK;
    item_if.state_code = StOff;
    item_if.hold_ms    = 32'd0;
    item_if.now_ms     = 32'd0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = 3'd0;
    pwdata             = 32'd0;
    burst_left         = 0;
    burst_max          = 32;
    gap_max            = 0;
    stall_mode         = STALL_NONE;
    ms_clock           = 32'd0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    apply_masks(32'd0, 32'd0);

    // Directed part: every kind of state, timing edges, the hold override
    // and its expiry, wrap of the deadline and of the timer, ignored words.
    send_word(FUNC_TICK, StOff, 32'd0, 32'd0);
    send_word(FUNC_STATE, StBoot, 32'd0, 32'd10);
    send_word(FUNC_STATE, StBoot, 32'd0, 32'd20);               // same state
    send_word(FUNC_STATE, StError, 32'd0, 32'd100);
    send_word(FUNC_TICK, 5'd31, 32'hFFFF_FFFF, 32'd299);        // one ms early
    send_word(FUNC_TICK, StOff, 32'd0, 32'd300);                // blink goes dark
    send_word(FUNC_STATE, StUpdate, 32'd0, 32'd400);            // pulse entry
    send_word(FUNC_TICK, StOff, 32'd0, 32'd419);
    send_word(FUNC_TICK, StOff, 32'd0, 32'd420);
    send_word(FUNC_TICK, StOff, 32'd0, 32'd1400);               // peak brightness
    send_word(FUNC_TICK, StOff, 32'd0, 32'd2400);               // back to zero
    send_word(FUNC_STATE, 5'd31, 32'd0, 32'd2410);              // invalid states
    send_word(FUNC_STATE, 5'd17, 32'd0, 32'd2415);
    send_word(FUNC_HOLD, 5'd20, 32'd100, 32'd2420);
    send_word(FuncUnused, StBoot, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(FUNC_HOLD, StLinkLost, 32'd1000, 32'd2500);
    send_word(FUNC_STATE, StResultOk, 32'd0, 32'd2600);         // forced to hold
    send_word(FUNC_STATE, StSafeMode, 32'd0, 32'd3499);
    send_word(FUNC_STATE, StResultOk, 32'd0, 32'd3500);         // deadline reached
    send_word(FUNC_HOLD, StButtonPair, 32'h0000_0100, 32'hFFFF_FF00);
    send_word(FUNC_STATE, StButtonWipe, 32'd0, 32'hFFFF_FF80);  // zero deadline held
    send_word(FUNC_HOLD, StOff, 32'hFFFF_FFFF, 32'hFFFF_FF90);  // already expired
    send_word(FUNC_STATE, StWifiTrial, 32'd0, 32'hFFFF_FFA0);
    send_word(FUNC_TICK, StOff, 32'd0, 32'h0000_0068);          // toggle across wrap
    send_word(FUNC_STATE, StOff, 32'd0, 32'h0000_0070);
    ms_clock = 32'h0000_0070;

    for (int unsigned p = 1; p <= RandomPhases; p++) begin
      settle();
      case (p)
        1: apply_masks(MaskAll, 32'd0);
        2: apply_masks(32'd0, MaskAll);
        3: apply_masks(MaskAll, MaskAll);
        4: apply_masks($urandom, $urandom);   // upper bits must be dropped
        5, 6: apply_masks($urandom_range(0, MaskAll), $urandom_range(0, MaskAll));
        default: apply_masks(32'd0, 32'd0);
      endcase
      // Phase four runs without any idling on either side.
      burst_left = 0;
      burst_max  = $urandom_range(1, 16);
      gap_max    = (p == 4) ? 0 : $urandom_range(2, 12);
      case (p % 4)
        0: stall_mode = STALL_NONE;
        1: stall_mode = STALL_RANDOM;
        2: stall_mode = STALL_PATTERN;
        default: stall_mode = STALL_RUNS;
      endcase
      for (int unsigned n = 0; n < WordsPerPhase; n++) begin
        send_random_word();
      end
    end

    settle();
    repeat (8) @(negedge clk_i);

    $display("Sent %0d request words over %0d mask settings,",
             sent_words, settings_applied);
    $display("with sender gaps and receiver stalls; compared %0d result words",
             checked);
    $display("(%0d pixel refreshes), %0d mismatches.", refreshes, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
